[design/pmc_pkg.sv]
`default_nettype none

package pmc_pkg;

   // Coordinate width of the cursor position.
   localparam int COORD_BITS_DEFAULT = 12;

   // Configuration register layout.
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  SCREEN_WIDTH_RESET  = 13'd800;
   localparam logic [CSR_DATA_W-1:0]  SCREEN_HEIGHT_RESET = 13'd600;

   // Bits of the first packet byte.
   localparam logic [7:0] SYNC_BIT = 8'h08;
   localparam logic [7:0] OVF_BITS = 8'hC0;
   localparam logic [7:0] BTN_MASK = 8'h07;
   localparam logic [2:0] LEFT_BIT = 3'h1;

   // Event codes.
   localparam logic [1:0] EV_MOVE    = 2'd0;
   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_RELEASE = 2'd2;

   // Assembled packet passed from the front end to the back end.
   typedef struct packed {
      logic [7:0] flags;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
   } pkt_type;

endpackage

`default_nettype wire

[design/pmc_front.sv]
`default_nettype none

module pmc_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic           req_from_aux,
   input  wire logic [7:0]     req_data_byte,
   output logic                push,
   output pmc_pkg::pkt_type    push_pkt,
   input  wire logic           queue_full
);
   import pmc_pkg::*;

   typedef enum logic [1:0] {
      PH_FLAGS = 2'd0,
      PH_X     = 2'd1,
      PH_Y     = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] flags_ff, flags_in;
   logic [7:0] x_ff, x_in;
   logic       accept;

   // A request is taken whenever the queue has room for a finished packet.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready && req_from_aux;

   // Packet assembly: sync check on the first byte, overflow drop on the last.
   always_comb begin
      phase_in = phase_ff;
      flags_in = flags_ff;
      x_in     = x_ff;
      push     = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_X: begin
               x_in     = req_data_byte;
               phase_in = PH_Y;
            end
            PH_Y: begin
               phase_in = PH_FLAGS;
               push     = (flags_ff & OVF_BITS) == 8'h00;
            end
            default: begin
               if ((req_data_byte & SYNC_BIT) == 8'h00) begin
                  phase_in = PH_FLAGS;
               end else begin
                  flags_in = req_data_byte;
                  phase_in = PH_X;
               end
            end
         endcase
      end
   end

   assign push_pkt = '{flags: flags_ff, x_byte: x_ff, y_byte: req_data_byte};

   // Phase and captured bytes.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAGS;
      end else begin
         phase_ff <= phase_in;
      end
      flags_ff <= flags_in;
      x_ff     <= x_in;
   end

endmodule

`default_nettype wire

[design/pmc_queue.sv]
`default_nettype none

module pmc_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  pmc_pkg::pkt_type   push_pkt,
   output logic               full,
   output logic               pop_valid,
   output pmc_pkg::pkt_type   pop_pkt,
   input  wire logic          pop
);
   import pmc_pkg::*;

   pkt_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full      = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_pkt   = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_pkt;
      end
   end

endmodule

`default_nettype wire

[design/pmc_back.sv]
`default_nettype none

module pmc_back #(
   parameter int COORD_BITS = pmc_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [pmc_pkg::CSR_DATA_W-1:0] screen_width,
   input  wire logic [pmc_pkg::CSR_DATA_W-1:0] screen_height,
   input  wire logic                          pkt_valid,
   input  pmc_pkg::pkt_type                   pkt,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_event_kind,
   output logic [COORD_BITS-1:0]              rsp_cursor_x,
   output logic [COORD_BITS-1:0]              rsp_cursor_y,
   output logic signed [7:0]                  rsp_delta_x,
   output logic signed [7:0]                  rsp_delta_y,
   output logic [2:0]                         rsp_buttons
);
   import pmc_pkg::*;

   localparam int SW = (COORD_BITS + 1 > CSR_DATA_W) ? COORD_BITS + 1 : CSR_DATA_W;
   localparam logic [SW-1:0] SIZE_MAX = SW'(1 << COORD_BITS);

   logic [COORD_BITS-1:0]   pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0]   pos_y_ff, pos_y_in;
   logic [2:0]              prev_btn_ff, prev_btn_in;
   logic                    valid_ff, valid_in;
   logic [1:0]              kind_ff, kind_in;
   logic [7:0]              dx_ff, dy_ff;
   logic [2:0]              btn_ff, btn_in;
   logic signed [COORD_BITS+1:0] x_sum, y_sum;
   logic [COORD_BITS:0]     size_x, size_y;

   // Screen size limited to 1 .. 2^COORD_BITS.
   function automatic logic [COORD_BITS:0] eff_size(input logic [CSR_DATA_W-1:0] sz);
      logic [SW-1:0] s;
      s = SW'(sz);
      if (s == '0) begin
         s = SW'(1);
      end
      if (s > SIZE_MAX) begin
         s = SIZE_MAX;
      end
      return s[COORD_BITS:0];
   endfunction

   // Clamp a signed sum into 0 .. size minus one.
   function automatic logic [COORD_BITS-1:0] clamp(input logic signed [COORD_BITS+1:0] v,
                                                   input logic [COORD_BITS:0] size);
      logic [COORD_BITS:0] top;
      top = size - (COORD_BITS+1)'(1);
      if (v[COORD_BITS+1]) begin
         return '0;
      end else if (v >= $signed({1'b0, size})) begin
         return top[COORD_BITS-1:0];
      end
      return v[COORD_BITS-1:0];
   endfunction

   assign size_x = eff_size(screen_width);
   assign size_y = eff_size(screen_height);
   assign x_sum  = $signed({2'b00, pos_x_ff}) + $signed({{(COORD_BITS-6){pkt.x_byte[7]}},
                                                          pkt.x_byte});
   assign y_sum  = $signed({2'b00, pos_y_ff}) - $signed({{(COORD_BITS-6){pkt.y_byte[7]}},
                                                          pkt.y_byte});

   // A packet is taken when the result register is free or being drained.
   assign pop = pkt_valid && (!valid_ff || rsp_ready);

   // Cursor move, button edge detection and result decision.
   always_comb begin
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      prev_btn_in = prev_btn_ff;
      btn_in      = pkt.flags[2:0] & BTN_MASK[2:0];
      kind_in     = EV_MOVE;
      valid_in    = valid_ff && !rsp_ready;
      if (((btn_in ^ prev_btn_ff) & LEFT_BIT) != 3'd0) begin
         kind_in = ((btn_in & LEFT_BIT) != 3'd0) ? EV_PRESS : EV_RELEASE;
      end
      if (pop) begin
         pos_x_in    = clamp(x_sum, size_x);
         pos_y_in    = clamp(y_sum, size_y);
         prev_btn_in = btn_in;
         valid_in    = (kind_in != EV_MOVE) || (pkt.x_byte != 8'h00)
                       || (pkt.y_byte != 8'h00);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         prev_btn_ff <= 3'd0;
         valid_ff    <= 1'b0;
      end else begin
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         prev_btn_ff <= prev_btn_in;
         valid_ff    <= valid_in;
      end
      if (pop) begin
         kind_ff <= kind_in;
         dx_ff   <= pkt.x_byte;
         dy_ff   <= pkt.y_byte;
         btn_ff  <= btn_in;
      end
   end

   // The result shows the cursor as it stands after its packet.
   assign rsp_valid      = valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_cursor_x   = pos_x_ff;
   assign rsp_cursor_y   = pos_y_ff;
   assign rsp_delta_x    = $signed(dx_ff);
   assign rsp_delta_y    = $signed(dy_ff);
   assign rsp_buttons    = btn_ff;

endmodule

`default_nettype wire

[design/ps2_mouse_packet_cursor.sv]
// A packet's result goes through the packet queue, then the result register, after
// its third byte is accepted. Throughput: one byte per cycle while the queue has room;
// the two-entry queue and the result register keep intake going while a result waits.
// Reset (synchronous, active high): assembly restarts at the first byte, cursor and
// button history clear to zero, screen size returns to 800 by 600.
`default_nettype none

module ps2_mouse_packet_cursor #(
   parameter int COORD_BITS = pmc_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [pmc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pmc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_from_aux,
   input  wire logic [7:0]                     req_data_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [1:0]                          rsp_event_kind,
   output logic [COORD_BITS-1:0]               rsp_cursor_x,
   output logic [COORD_BITS-1:0]               rsp_cursor_y,
   output logic signed [7:0]                   rsp_delta_x,
   output logic signed [7:0]                   rsp_delta_y,
   output logic [2:0]                          rsp_buttons
);
   import pmc_pkg::*;

   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic    push, queue_full, pkt_valid, pop;
   pkt_type push_pkt, pop_pkt;

   // Screen size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata;
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pmc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_from_aux  (req_from_aux),
      .req_data_byte (req_data_byte),
      .push          (push),
      .push_pkt      (push_pkt),
      .queue_full    (queue_full)
   );

   pmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pkt  (push_pkt),
      .full      (queue_full),
      .pop_valid (pkt_valid),
      .pop_pkt   (pop_pkt),
      .pop       (pop)
   );

   pmc_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .screen_width   (width_ff),
      .screen_height  (height_ff),
      .pkt_valid      (pkt_valid),
      .pkt            (pop_pkt),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_cursor_x   (rsp_cursor_x),
      .rsp_cursor_y   (rsp_cursor_y),
      .rsp_delta_x    (rsp_delta_x),
      .rsp_delta_y    (rsp_delta_y),
      .rsp_buttons    (rsp_buttons)
   );

endmodule

`default_nettype wire

[bench/tb_ps2_mouse_packet_cursor.sv]
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor;
   import pmc_pkg::*;

   localparam int COORD_W        = COORD_BITS_DEFAULT;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_TARGET  = 620;

   // Assembly position inside a three-byte packet; the fourth code never arises.
   typedef enum logic [1:0] {
      WAIT_FLAGS = 2'd0,
      WAIT_X     = 2'd1,
      WAIT_Y     = 2'd2
   } byte_phase_type;

   // One cursor event as the block reports it.
   typedef struct packed {
      logic [1:0]         kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [7:0]         dx;
      logic [7:0]         dy;
      logic [2:0]         btn;
   } cursor_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SCREEN_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic       req_from_aux  = 1'b0;
   logic [7:0] req_data_byte = 8'h00;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_event_kind;
   logic [COORD_W-1:0] rsp_cursor_x;
   logic [COORD_W-1:0] rsp_cursor_y;
   logic signed [7:0]  rsp_delta_x;
   logic signed [7:0]  rsp_delta_y;
   logic [2:0]         rsp_buttons;

   // Shadow of the block's packet assembly, cursor and screen size.
   byte_phase_type     asm_phase = WAIT_FLAGS;
   logic [7:0]         asm_flags = 8'h00;
   logic [7:0]         asm_x_byte = 8'h00;
   logic [COORD_W-1:0] cur_x = '0;
   logic [COORD_W-1:0] cur_y = '0;
   logic [2:0]         prev_btn = 3'b000;
   logic [CSR_DATA_W-1:0] screen_w = SCREEN_WIDTH_RESET;
   logic [CSR_DATA_W-1:0] screen_h = SCREEN_HEIGHT_RESET;

   cursor_event_type pending_events[$];
   int error_count      = 0;
   int mouse_bytes_sent = 0;
   int quiet_cycles     = 0;
   int rsp_hold_off     = 0;
   bit sender_idle      = 1'b1;
   bit receiver_idle    = 1'b1;
   bit noise_on         = 1'b0;

   ps2_mouse_packet_cursor dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_from_aux   (req_from_aux),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_cursor_x   (rsp_cursor_x),
      .rsp_cursor_y   (rsp_cursor_y),
      .rsp_delta_x    (rsp_delta_x),
      .rsp_delta_y    (rsp_delta_y),
      .rsp_buttons    (rsp_buttons)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Clamp a moved coordinate into the screen; size 0 acts as 1, oversize as full range.
   function automatic logic [COORD_W-1:0] clamp_to_screen(input int v,
                                                          input logic [CSR_DATA_W-1:0] size);
      int lim;
      lim = (size == 0) ? 1 : int'(size);
      if (lim > (1 << COORD_W)) lim = 1 << COORD_W;
      if (v < 0) return '0;
      if (v >= lim) return COORD_W'(lim - 1);
      return COORD_W'(v);
   endfunction

   // Advance the packet assembly by one byte; returns 1 when a cursor event results.
   function automatic bit decode_mouse_byte(input logic aux, input logic [7:0] data,
                                            output cursor_event_type ev);
      logic [2:0] btn;
      logic [1:0] kind;
      int dx;
      int dy;
      ev = '0;
      if (!aux) return 1'b0;
      if (asm_phase == WAIT_X) begin
         asm_x_byte = data;
         asm_phase  = WAIT_Y;
         return 1'b0;
      end
      if (asm_phase != WAIT_Y) begin
         // A first byte must carry the sync bit, or it is dropped.
         if ((data & SYNC_BIT) == 0) begin
            asm_phase = WAIT_FLAGS;
            return 1'b0;
         end
         asm_flags = data;
         asm_phase = WAIT_X;
         return 1'b0;
      end

      asm_phase = WAIT_FLAGS;
      if ((asm_flags & OVF_BITS) != 0) return 1'b0;

      dx = $signed(asm_x_byte);
      dy = $signed(data);
      cur_x = clamp_to_screen(int'(cur_x) + dx, screen_w);
      cur_y = clamp_to_screen(int'(cur_y) - dy, screen_h);

      btn  = 3'(asm_flags & BTN_MASK);
      kind = EV_MOVE;
      if ((btn & LEFT_BIT) != (prev_btn & LEFT_BIT))
         kind = ((btn & LEFT_BIT) != 0) ? EV_PRESS : EV_RELEASE;
      prev_btn = btn;

      if (kind == EV_MOVE && dx == 0 && dy == 0) return 1'b0;
      ev.kind = kind;
      ev.x    = cur_x;
      ev.y    = cur_y;
      ev.dx   = asm_x_byte;
      ev.dy   = data;
      ev.btn  = btn;
      return 1'b1;
   endfunction

   function automatic void check_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   function automatic logic [7:0] random_delta();
      logic [7:0] extremes[4];
      extremes = '{8'h7F, 8'h80, 8'h01, 8'hFF};
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return extremes[$urandom_range(0, 3)];
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_screen_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CSR_DATA_W'($urandom_range(4097, 8191));
         2: return CSR_DATA_W'($urandom_range(1, 16));
         default: return CSR_DATA_W'($urandom_range(1, 4096));
      endcase
   endfunction

   // Offer one request; valid stays high after acceptance unless the next one waits.
   task automatic send_request(input logic aux, input logic [7:0] data);
      int gap;
      cursor_event_type ev;
      gap = sender_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_from_aux  <= aux;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      if (decode_mouse_byte(aux, data, ev)) pending_events.push_back(ev);
      if (aux) mouse_bytes_sent++;
   endtask

   // Send a full packet from a clean packet boundary, with optional stray keyboard bytes.
   task automatic send_mouse_packet(input logic [7:0] flags, input logic [7:0] dx,
                                    input logic [7:0] dy);
      logic [7:0] bytes[3];
      bytes = '{flags, dx, dy};
      while (asm_phase != WAIT_FLAGS) send_request(1'b1, 8'($urandom_range(0, 255)));
      foreach (bytes[i]) begin
         if (noise_on && $urandom_range(0, 15) == 0)
            send_request(1'b0, 8'($urandom_range(0, 255)));
         send_request(1'b1, bytes[i]);
      end
   endtask

   // Let every outstanding result come back and the pipeline settle.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both screen registers in random order while the block is idle.
   task automatic set_screen(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      bit height_first;
      wait_for_drain();
      height_first = $urandom_range(0, 1);
      csr_we    <= 1'b1;
      csr_index <= height_first ? CSR_SCREEN_HEIGHT : CSR_SCREEN_WIDTH;
      csr_wdata <= height_first ? h : w;
      @(posedge clock);
      if (height_first) screen_h = h; else screen_w = w;
      csr_index <= height_first ? CSR_SCREEN_WIDTH : CSR_SCREEN_HEIGHT;
      csr_wdata <= height_first ? w : h;
      @(posedge clock);
      if (height_first) screen_w = w; else screen_h = h;
      csr_we <= 1'b0;
   endtask

   // One random unit: mostly well-formed packets, some dropped or stray bytes.
   task automatic send_random_unit();
      int pick;
      logic [7:0] flags;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         flags = 8'($urandom_range(0, 255)) | SYNC_BIT;
         if ($urandom_range(0, 7) != 0) flags = flags & ~OVF_BITS;
         send_mouse_packet(flags, random_delta(), random_delta());
      end else if (pick < 88) begin
         send_request(1'b1, 8'($urandom_range(0, 255)) & ~SYNC_BIT);
      end else if (pick < 96) begin
         send_request(1'b1, 8'($urandom_range(0, 255)));
      end else begin
         send_request(1'b0, 8'($urandom_range(0, 255)));
      end
   endtask

   // Ignored bytes, lost sync, both overflow bits, button edges and quiet packets.
   task automatic test_directed_packets();
      send_request(1'b0, 8'hFF);
      send_request(1'b1, 8'h00);
      send_mouse_packet(8'h09, 8'h80, 8'h7F);
      send_mouse_packet(8'h08, 8'h7F, 8'h80);
      send_mouse_packet(8'h08, 8'h00, 8'h00);
      send_mouse_packet(8'h4E, 8'h10, 8'h10);
      send_mouse_packet(8'h8F, 8'h10, 8'h10);
      // A keyboard byte in the middle of a packet must not disturb it.
      send_request(1'b1, 8'h0E);
      send_request(1'b0, 8'h55);
      send_request(1'b1, 8'h01);
      send_request(1'b1, 8'h00);
      send_request(1'b1, 8'hF7);
      send_mouse_packet(8'h3F, 8'hFF, 8'h01);
      // Release with no motion still gives an event.
      send_mouse_packet(8'h08, 8'h00, 8'h00);
   endtask

   // Push the cursor to the far corner, then shrink and degenerate the screen.
   task automatic test_screen_sizes();
      set_screen(13'd4096, 13'd4096);
      repeat (48)
         send_mouse_packet(SYNC_BIT | 8'($urandom_range(0, 7)),
                           8'($urandom_range(64, 127)), 8'($urandom_range(128, 192)));
      set_screen(13'd8191, 13'd4097);
      repeat (4)
         send_mouse_packet(SYNC_BIT | 8'($urandom_range(0, 7)),
                           8'($urandom_range(64, 127)), 8'($urandom_range(128, 192)));
      // The cursor now sits beyond the reduced screen and the next packet clamps it.
      set_screen(13'd7, 13'd3);
      repeat (4) send_mouse_packet(SYNC_BIT | 8'($urandom_range(0, 7)), random_delta(),
                                   random_delta());
      set_screen(13'd0, 13'd0);
      repeat (4) send_mouse_packet(SYNC_BIT | 8'($urandom_range(0, 7)), random_delta(),
                                   random_delta());
      set_screen(13'd1, 13'd1);
      repeat (4) send_mouse_packet(SYNC_BIT | 8'($urandom_range(0, 7)), random_delta(),
                                   random_delta());
      set_screen(13'd4096, 13'd1);
      repeat (4) send_mouse_packet(SYNC_BIT | 8'($urandom_range(0, 7)), random_delta(),
                                   random_delta());
   endtask

   // Random phases with new screen sizes; every third phase runs without idling.
   task automatic test_random_traffic();
      int phase_count;
      phase_count = 0;
      noise_on = 1'b1;
      while (mouse_bytes_sent < RANDOM_TARGET) begin
         if ($urandom_range(0, 3) != 0) set_screen(random_screen_size(), random_screen_size());
         sender_idle   = (phase_count % 3 != 2);
         receiver_idle = (phase_count % 3 != 2);
         repeat (20) send_random_unit();
         phase_count++;
      end
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   // The receiver holds off while requests keep coming until the block stalls its input.
   task automatic test_backpressure();
      set_screen(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
      sender_idle  = 1'b0;
      noise_on     = 1'b0;
      rsp_hold_off = HOLD_OFF_CYCLES;
      repeat (60)
         send_mouse_packet(SYNC_BIT | 8'($urandom_range(0, 7)), 8'($urandom_range(1, 255)),
                           8'($urandom_range(0, 255)));
      sender_idle = 1'b1;
   endtask

   // Receiver: random stalls, one long hold-off on request, and the result check.
   initial begin : result_checker
      int stall;
      cursor_event_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_idle ? $urandom_range(0, 13) : 0;
         if (rsp_hold_off > 0) begin
            stall = rsp_hold_off;
            rsp_hold_off = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_events.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual kind %0d x %0d y %0d",
                     $time, rsp_event_kind, rsp_cursor_x, rsp_cursor_y);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind", want.kind, rsp_event_kind);
            check_field("cursor_x", want.x, rsp_cursor_x);
            check_field("cursor_y", want.y, rsp_cursor_y);
            check_field("delta_x", $signed(want.dx), $signed(rsp_delta_x));
            check_field("delta_y", $signed(want.dy), $signed(rsp_delta_y));
            check_field("buttons", want.btn, rsp_buttons);
         end
      end
   end

   // Watchdog: too long without any accepted request or result ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_packets();
      test_screen_sizes();
      test_random_traffic();
      test_backpressure();
      wait_for_drain();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
